### rtl/core/fatam_pkg.sv
`timescale 1ns / 1ps

package fatam_pkg;

  localparam int AdcBits = 12;
  localparam int QuoW    = 8;
  localparam int DivW    = AdcBits + QuoW;
  localparam int CmpW    = AdcBits + 2;
  localparam int SnapW   = 7;
  localparam int FidW    = 4;

  localparam logic [7:0] CloseAngle   = 8'd190;
  localparam logic [7:0] OpenAngleDef = 8'd49;
  localparam logic [7:0] OpenAngleF2  = 8'd44;

  localparam logic [SnapW-1:0] OpenSnapDef  = 7'd8;
  localparam logic [SnapW-1:0] CloseSnapDef = 7'd6;
  localparam logic [SnapW-1:0] OpenSnapF1   = 7'd10;
  localparam logic [SnapW-1:0] CloseSnapF1  = 7'd8;
  localparam logic [SnapW-1:0] OpenSnapF3   = 7'd100;
  localparam logic [SnapW-1:0] CloseSnapF3  = 7'd25;

  localparam logic [FidW-1:0] FingerOne   = 4'd1;
  localparam logic [FidW-1:0] FingerTwo   = 4'd2;
  localparam logic [FidW-1:0] FingerThree = 4'd3;

  typedef enum logic [1:0] {
    CfgCalibrated = 2'd0,
    CfgOpenRef    = 2'd1,
    CfgCloseRef   = 2'd2,
    CfgFingerId   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic               calibrated;
    logic [AdcBits-1:0] open_adc;
    logic [AdcBits-1:0] close_adc;
    logic [FidW-1:0]    finger_id;
  } cfg_t;

  typedef struct packed {
    logic               early;
    logic [7:0]         base;
    logic [7:0]         gain;
    logic [AdcBits-1:0] travel;
    logic [AdcBits-1:0] span;
  } class_t;

  typedef struct packed {
    logic            early;
    logic [7:0]      base;
    logic [DivW-1:0] den;
    logic [DivW-1:0] rem;
    logic [QuoW-1:0] quo;
  } div_t;

endpackage

### rtl/core/fatam_classify.sv
`timescale 1ns / 1ps

module fatam_classify (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fatam_pkg::cfg_t             cfg_i,
  input  logic                        valid_i,
  input  logic [fatam_pkg::AdcBits-1:0] sample_i,
  output logic                        ready_o,
  output logic                        valid_o,
  output fatam_pkg::class_t           data_o,
  input  logic                        ready_i
);

  localparam int CmpW = fatam_pkg::CmpW;
  localparam int AdcBits = fatam_pkg::AdcBits;

  logic                       valid_q;
  fatam_pkg::class_t          data_q, data_d;
  logic [7:0]                 open_deg;
  logic [fatam_pkg::SnapW-1:0] open_snap, close_snap;
  logic signed [CmpW-1:0]     xs, os, cs, osn, csn;
  logic                       invalid, snap_open, snap_close, desc;
  logic [AdcBits-1:0]         xc;

  always_comb begin
    open_deg = (cfg_i.finger_id == fatam_pkg::FingerTwo) ? fatam_pkg::OpenAngleF2
                                                        : fatam_pkg::OpenAngleDef;
    priority if (cfg_i.finger_id == fatam_pkg::FingerOne) begin
      open_snap  = fatam_pkg::OpenSnapF1;
      close_snap = fatam_pkg::CloseSnapF1;
    end else if (cfg_i.finger_id == fatam_pkg::FingerThree) begin
      open_snap  = fatam_pkg::OpenSnapF3;
      close_snap = fatam_pkg::CloseSnapF3;
    end else begin
      open_snap  = fatam_pkg::OpenSnapDef;
      close_snap = fatam_pkg::CloseSnapDef;
    end
    xs  = $signed({2'b00, sample_i});
    os  = $signed({2'b00, cfg_i.open_adc});
    cs  = $signed({2'b00, cfg_i.close_adc});
    osn = $signed({{(CmpW-fatam_pkg::SnapW){1'b0}}, open_snap});
    csn = $signed({{(CmpW-fatam_pkg::SnapW){1'b0}}, close_snap});
    desc    = cfg_i.open_adc > cfg_i.close_adc;
    invalid = !cfg_i.calibrated || (cfg_i.open_adc == cfg_i.close_adc);
    data_d  = '0;
    if (desc) begin
      snap_open  = xs >= (os - osn);
      snap_close = xs <= (cs + csn);
      xc = sample_i;
      if (xc > cfg_i.open_adc)  xc = cfg_i.open_adc;
      if (xc < cfg_i.close_adc) xc = cfg_i.close_adc;
      data_d.travel = cfg_i.open_adc - xc;
      data_d.span = cfg_i.open_adc - cfg_i.close_adc;
    end else begin
      snap_open  = xs <= (os + osn);
      snap_close = xs >= (cs - csn);
      xc = sample_i;
      if (xc < cfg_i.open_adc)  xc = cfg_i.open_adc;
      if (xc > cfg_i.close_adc) xc = cfg_i.close_adc;
      data_d.travel = xc - cfg_i.open_adc;
      data_d.span = cfg_i.close_adc - cfg_i.open_adc;
    end
    data_d.early = invalid || snap_open || snap_close;
    data_d.gain  = fatam_pkg::CloseAngle - open_deg;
    priority if (invalid) begin
      data_d.base = fatam_pkg::OpenAngleDef;
    end else if (snap_open) begin
      data_d.base = open_deg;
    end else if (snap_close) begin
      data_d.base = fatam_pkg::CloseAngle;
    end else begin
      data_d.base = open_deg;
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  a_interp_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !data_q.early |-> data_q.span != '0 && data_q.travel <= data_q.span)
    else $error("interpolation distance outside span");

endmodule

### rtl/core/fatam_scale.sv
`timescale 1ns / 1ps

module fatam_scale (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  fatam_pkg::class_t data_i,
  output logic              ready_o,
  output logic              valid_o,
  output fatam_pkg::div_t   data_o,
  input  logic              ready_i
);

  localparam int DivW = fatam_pkg::DivW;

  logic            valid_q;
  fatam_pkg::div_t data_q, data_d;

  always_comb begin
    data_d       = '0;
    data_d.early = data_i.early;
    data_d.base  = data_i.base;
    data_d.rem   = DivW'(data_i.travel) * DivW'(data_i.gain);
    data_d.den   = {{(DivW-fatam_pkg::AdcBits-fatam_pkg::QuoW+1){1'b0}}, data_i.span,
                    {(fatam_pkg::QuoW-1){1'b0}}};
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

### rtl/core/fatam_div_stage.sv
`timescale 1ns / 1ps

module fatam_div_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  fatam_pkg::div_t data_i,
  output logic            ready_o,
  output logic            valid_o,
  output fatam_pkg::div_t data_o,
  input  logic            ready_i
);

  logic            valid_q;
  fatam_pkg::div_t data_q, data_d;
  logic            bit_hi, bit_lo;
  logic [fatam_pkg::DivW-1:0] rem_mid;

  always_comb begin
    data_d  = data_i;
    bit_hi  = data_i.rem >= data_i.den;
    rem_mid = bit_hi ? (data_i.rem - data_i.den) : data_i.rem;
    rem_mid = rem_mid << 1;
    bit_lo  = rem_mid >= data_i.den;
    data_d.rem = bit_lo ? (rem_mid - data_i.den) : rem_mid;
    data_d.rem = data_d.rem << 1;
    data_d.quo = {data_i.quo[fatam_pkg::QuoW-3:0], bit_hi, bit_lo};
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !data_q.early |-> data_q.rem < (data_q.den << 1))
    else $error("partial remainder out of range");

endmodule

### rtl/core/fatam_finish.sv
`timescale 1ns / 1ps

module fatam_finish (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  fatam_pkg::div_t data_i,
  output logic            ready_o,
  output logic            valid_o,
  output logic [7:0]      angle_o,
  input  logic            stall_i
);

  logic       valid_q;
  logic [7:0] angle_q, angle_d;

  assign angle_d = data_i.early ? data_i.base : (data_i.base + data_i.quo);
  assign ready_o = !valid_q || !stall_i;
  assign valid_o = valid_q;
  assign angle_o = angle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      angle_q <= angle_d;
    end
  end

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> angle_q >= fatam_pkg::OpenAngleF2 && angle_q <= fatam_pkg::CloseAngle)
    else $error("angle outside servo range");

endmodule

### rtl/core/flex_adc_to_angle_map_top.sv
`timescale 1ns / 1ps

// Maps a flex sensor ADC sample to a servo angle between the calibrated open and
// close references (open angle 49, or 44 for finger 2; close angle 190), with
// snap bands near both ends and truncating linear interpolation in between.
// Uncalibrated or equal references give 49. One sample per cycle enters unless
// in_stall_o is high. Stages: classify, scale multiply, four radix-4 divider
// stages, output register. Write configuration only while the pipeline is empty.

module flex_adc_to_angle_map_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [fatam_pkg::AdcBits-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [fatam_pkg::AdcBits-1:0] sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    angle_o
);

  localparam int NumDiv = fatam_pkg::QuoW / 2;

  fatam_pkg::cfg_t   cfg_q;
  logic              cls_valid, cls_ready, in_ready;
  fatam_pkg::class_t cls_data;
  logic              div_valid [NumDiv+1];
  logic              div_ready [NumDiv+1];
  fatam_pkg::div_t   div_data  [NumDiv+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (fatam_pkg::cfg_idx_e'(cfg_idx_i))
        fatam_pkg::CfgCalibrated: cfg_q.calibrated <= cfg_wdata_i[0];
        fatam_pkg::CfgOpenRef:    cfg_q.open_adc   <= cfg_wdata_i;
        fatam_pkg::CfgCloseRef:   cfg_q.close_adc  <= cfg_wdata_i;
        fatam_pkg::CfgFingerId:   cfg_q.finger_id  <= cfg_wdata_i[fatam_pkg::FidW-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = !in_ready;

  fatam_classify u_classify (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .valid_i  (in_valid_i),
    .sample_i (sample_i),
    .ready_o  (in_ready),
    .valid_o  (cls_valid),
    .data_o   (cls_data),
    .ready_i  (cls_ready)
  );

  fatam_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cls_valid),
    .data_i  (cls_data),
    .ready_o (cls_ready),
    .valid_o (div_valid[0]),
    .data_o  (div_data[0]),
    .ready_i (div_ready[0])
  );

  for (genvar g = 0; g < NumDiv; g++) begin : g_div
    fatam_div_stage u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (div_valid[g]),
      .data_i  (div_data[g]),
      .ready_o (div_ready[g]),
      .valid_o (div_valid[g+1]),
      .data_o  (div_data[g+1]),
      .ready_i (div_ready[g+1])
    );
  end

  fatam_finish u_finish (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_valid[NumDiv]),
    .data_i  (div_data[NumDiv]),
    .ready_o (div_ready[NumDiv]),
    .valid_o (out_valid_o),
    .angle_o (angle_o),
    .stall_i (out_stall_i)
  );

endmodule

### tb/flex_adc_to_angle_map_checker.sv
`timescale 1ns / 1ps

module flex_adc_to_angle_map_checker
  import fatam_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [AdcBits-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [AdcBits-1:0] sample_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [7:0]         angle_i,
  output int                 pending_o,
  output int                 fail_count_o
);

  logic               calibrated;
  logic [AdcBits-1:0] open_adc;
  logic [AdcBits-1:0] close_adc;
  logic [FidW-1:0]    finger_id;
  logic [7:0]         angle_q[$];

  function automatic logic [7:0] predict_angle(input logic [AdcBits-1:0] s);
    int x;
    int o;
    int c;
    int base;
    int open_snap;
    int close_snap;
    int travel;
    int span;
    x          = int'(s);
    o          = int'(open_adc);
    c          = int'(close_adc);
    base       = int'(OpenAngleDef);
    open_snap  = int'(OpenSnapDef);
    close_snap = int'(CloseSnapDef);
    if (!calibrated || o == c) return OpenAngleDef;
    if (finger_id == FingerTwo) base = int'(OpenAngleF2);
    if (finger_id == FingerOne) begin
      open_snap  = int'(OpenSnapF1);
      close_snap = int'(CloseSnapF1);
    end else if (finger_id == FingerThree) begin
      open_snap  = int'(OpenSnapF3);
      close_snap = int'(CloseSnapF3);
    end
    if (o > c) begin
      if (x >= o - open_snap) return 8'(base);
      if (x <= c + close_snap) return CloseAngle;
      if (x > o) x = o;
      if (x < c) x = c;
      travel = o - x;
      span = o - c;
    end else begin
      if (x <= o + open_snap) return 8'(base);
      if (x >= c - close_snap) return CloseAngle;
      if (x < o) x = o;
      if (x > c) x = c;
      travel = x - o;
      span = c - o;
    end
    return 8'(base + (travel * (int'(CloseAngle) - base)) / span);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [7:0] want;
    if (!rst_ni) begin
      calibrated   <= 1'b0;
      open_adc     <= '0;
      close_adc    <= '0;
      finger_id    <= '0;
      angle_q.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgCalibrated: calibrated <= cfg_wdata_i[0];
          CfgOpenRef:    open_adc   <= cfg_wdata_i;
          CfgCloseRef:   close_adc  <= cfg_wdata_i;
          CfgFingerId:   finger_id  <= cfg_wdata_i[FidW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) angle_q.push_back(predict_angle(sample_i));
      if (out_valid_i && !out_stall_i) begin
        if (angle_q.size() == 0) begin
          $error("angle: expected none, actual %0d", angle_i);
          fail_count_o++;
        end else begin
          want = angle_q.pop_front();
          if (angle_i !== want) begin
            $error("angle: expected %0d, actual %0d", want, angle_i);
            fail_count_o++;
          end
        end
      end
      pending_o = angle_q.size();
    end
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import fatam_pkg::*;

  localparam int AdcMax = (1 << AdcBits) - 1;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  cfg_idx_e           cfg_idx;
  logic [AdcBits-1:0] cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic [AdcBits-1:0] sample;
  logic               out_valid;
  logic               out_stall;
  logic [7:0]         angle;
  int                 pending;
  int                 fail_count;
  bit                 quiet;

  always #5 clk = ~clk;

  flex_adc_to_angle_map_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .sample_i   (sample),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .angle_o    (angle)
  );

  flex_adc_to_angle_map_checker angle_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .sample_i    (sample),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .angle_i     (angle),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  task automatic send_sample(input logic [AdcBits-1:0] s);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    sample   <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_idle();
    @(negedge clk) in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [AdcBits-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
  endtask

  // Upper write-data bits of the narrow registers are random; the block must drop them.
  task automatic load_calibration(input logic cal, input logic [AdcBits-1:0] open_adc,
                                  input logic [AdcBits-1:0] close_adc,
                                  input logic [FidW-1:0] fid);
    wait_idle();
    write_reg(CfgCalibrated, {(AdcBits-1)'($urandom), cal});
    write_reg(CfgOpenRef, open_adc);
    write_reg(CfgCloseRef, close_adc);
    write_reg(CfgFingerId, {(AdcBits-FidW)'($urandom), fid});
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  function automatic logic [AdcBits-1:0] pick_sample(input int open_adc, input int close_adc);
    int v;
    case ($urandom_range(0, 5))
      0, 1:    v = int'($urandom_range(0, AdcMax));
      2:       v = open_adc + int'($urandom_range(0, 240)) - 120;
      3:       v = close_adc + int'($urandom_range(0, 80)) - 40;
      default: begin
        if (open_adc < close_adc) v = int'($urandom_range(open_adc, close_adc));
        else v = int'($urandom_range(close_adc, open_adc));
      end
    endcase
    if (v < 0) v = 0;
    if (v > AdcMax) v = AdcMax;
    return AdcBits'(v);
  endfunction

  initial begin
    int stall_len;
    @(posedge rst_n);
    forever begin
      stall_len = quiet ? 0 : $urandom_range(0, 10);
      if (stall_len > 0) begin
        @(negedge clk) out_stall <= 1'b1;
        repeat (stall_len - 1) @(negedge clk);
      end
      @(negedge clk) out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    #(5_000_000);
    $display("tb: errors");
    $finish;
  end

  initial begin
    int o;
    int c;
    int d;
    logic cal;
    logic [FidW-1:0] fid;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = CfgCalibrated;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    sample    = '0;
    out_stall = 1'b0;
    quiet     = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // not calibrated after reset
    send_sample(12'd0);
    send_sample(12'd4095);
    // equal references
    load_calibration(1'b1, 12'd2000, 12'd2000, 4'd0);
    send_sample(12'd2000);
    // open above close, band edges
    load_calibration(1'b1, 12'd3000, 12'd1000, 4'd0);
    send_sample(12'd2992);
    send_sample(12'd2991);
    send_sample(12'd1006);
    send_sample(12'd1007);
    send_sample(12'd2000);
    // open below close at full scale, finger two
    load_calibration(1'b1, 12'd0, 12'd4095, FingerTwo);
    send_sample(12'd0);
    send_sample(12'd8);
    send_sample(12'd9);
    send_sample(12'd4089);
    send_sample(12'd4088);
    send_sample(12'd2048);
    // wide bands reaching past the ADC range
    load_calibration(1'b1, 12'd4080, 12'd10, FingerThree);
    send_sample(12'd4095);
    send_sample(12'd0);
    // overlapping bands, open band first
    load_calibration(1'b1, 12'd1000, 12'd1050, FingerThree);
    send_sample(12'd1040);
    send_sample(12'd1101);
    load_calibration(1'b1, 12'd4095, 12'd0, FingerOne);
    send_sample(12'd4085);
    send_sample(12'd4084);
    send_sample(12'd8);
    send_sample(12'd9);
    load_calibration(1'b1, 12'd100, 12'd200, 4'd15);
    send_sample(12'd150);

    for (int phase = 0; phase < 18; phase++) begin
      case ($urandom_range(0, 7))
        0: begin
          o = 0;
          c = AdcMax;
        end
        1: begin
          o = AdcMax;
          c = 0;
        end
        2: begin
          o = int'($urandom_range(0, AdcMax));
          c = o;
        end
        3: begin
          o = int'($urandom_range(0, AdcMax));
          d = int'($urandom_range(1, 200));
          c = $urandom_range(0, 1) ? o + d : o - d;
          if (c < 0) c = 0;
          if (c > AdcMax) c = AdcMax;
        end
        default: begin
          o = int'($urandom_range(0, AdcMax));
          c = int'($urandom_range(0, AdcMax));
        end
      endcase
      cal = ($urandom_range(0, 7) != 0);
      fid = ($urandom_range(0, 3) == 0) ? FidW'($urandom) : FidW'($urandom_range(0, 3));
      load_calibration(cal, AdcBits'(o), AdcBits'(c), fid);
      quiet = (phase % 4 == 3);
      for (int n = 0; n < 100; n++) send_sample(pick_sample(o, c));
      quiet = 1'b0;
    end

    wait_idle();
    if (fail_count == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
